// ===== rtl/mfd_pkg.sv =====
// Shared types and constants for the meter frame deframer.
// Result record, status codes and reset defaults; no dependencies.
package mfd_pkg;

  localparam int ADDRESS_BYTES_DEF = 6;

  localparam logic [7:0] START_BYTE_RST = 8'h68;
  localparam logic [7:0] END_BYTE_RST   = 8'h16;

  localparam logic CFG_START_BYTE = 1'b0;
  localparam logic CFG_END_BYTE   = 1'b1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_START   = 3'd1;
  localparam logic [2:0] ST_NO_START2  = 3'd2;
  localparam logic [2:0] ST_TRUNCATED  = 3'd3;
  localparam logic [2:0] ST_NO_END     = 3'd4;
  localparam logic [2:0] ST_BAD_SUM    = 3'd5;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload;
    logic [47:0] meter_address;
    logic [7:0]  control_code;
    logic [7:0]  data_length;
    logic [2:0]  status;
    logic [7:0]  consumed;
  } res_t;

endpackage

// ===== rtl/meter_frame_deframer.sv =====
// Meter frame deframer top level: byte-wide frame parser with output skid.
// Depends on mfd_pkg for the result record and status codes.
//
// Takes one byte of a received buffer per cycle unless in_stall is high, and
// parses one meter frame per buffer: start byte, address, second start byte,
// control, length, data, checksum and end byte. Each data byte but one that
// ends the buffer leaves at once as a tentative payload transfer (kind 0);
// one status transfer (kind 1) closes the frame, and the bytes after it up to
// buffer_last are dropped. Throughput is one byte per cycle unless in_stall
// is high; the whole parse step is a single update of the frame state
// registers into the result register. A result register plus one skid entry
// sit on the output; in_stall rises only while the skid entry is occupied, so
// after a one-cycle out_stall the input waits until the skid entry drains.
// start_byte and end_byte are written through the cfg port; the user must write them while idle, unenforced here.
module meter_frame_deframer
  import mfd_pkg::*;
#(
  parameter int ADDRESS_BYTES = ADDRESS_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_buffer_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_payload,
  output logic [47:0] out_meter_address,
  output logic [7:0]  out_control_code,
  output logic [7:0]  out_data_length,
  output logic [2:0]  out_status,
  output logic [7:0]  out_consumed
);

  localparam int ADDR_W = ADDRESS_BYTES * 8;

  localparam logic [3:0] PH_HUNT   = 4'd0;
  localparam logic [3:0] PH_ADDR   = 4'd1;
  localparam logic [3:0] PH_START2 = 4'd2;
  localparam logic [3:0] PH_CTRL   = 4'd3;
  localparam logic [3:0] PH_LEN    = 4'd4;
  localparam logic [3:0] PH_DATA   = 4'd5;
  localparam logic [3:0] PH_CS     = 4'd6;
  localparam logic [3:0] PH_END    = 4'd7;
  localparam logic [3:0] PH_DONE   = 4'd8;

  logic [7:0]        start_byte_r, end_byte_r;
  logic [3:0]        phase_r, phase_nxt;
  logic [7:0]        idx_r, idx_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [7:0]        ctrl_r, ctrl_nxt;
  logic [7:0]        len_r, len_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [7:0]        pos_r, pos_nxt;
  logic              good_r, good_nxt;

  logic              out_valid_r, skid_valid_r;
  res_t              out_r, skid_r;

  logic              in_fire;
  logic              emit;
  logic              is_stat;
  logic [2:0]        code;
  logic [7:0]        cons;
  logic [7:0]        pos_inc;
  logic [63:0]       addr_ext;
  res_t              res;

  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !in_stall;
  assign pos_inc  = pos_r + 8'd1;

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    addr_nxt  = addr_r;
    ctrl_nxt  = ctrl_r;
    len_nxt   = len_r;
    sum_nxt   = sum_r;
    pos_nxt   = pos_r;
    good_nxt  = good_r;
    emit      = 1'b0;
    is_stat   = 1'b0;
    code      = ST_OK;
    cons      = 8'd0;
    addr_ext  = 64'd0;
    res       = '0;
    if (in_fire) begin
      pos_nxt = pos_inc;
      case (phase_r)
        PH_HUNT: begin
          if (in_rx_byte == start_byte_r) begin
            idx_nxt   = 8'd0;
            addr_nxt  = '0;
            ctrl_nxt  = 8'd0;
            len_nxt   = 8'd0;
            good_nxt  = 1'b0;
            sum_nxt   = in_rx_byte;
            phase_nxt = PH_ADDR;
          end
        end
        PH_ADDR: begin
          for (int i = 0; i < ADDRESS_BYTES; i++) begin
            if (idx_r == 8'(i)) addr_nxt[i*8 +: 8] = in_rx_byte;
          end
          sum_nxt = sum_r + in_rx_byte;
          idx_nxt = idx_r + 8'd1;
          if (idx_nxt >= 8'(ADDRESS_BYTES)) phase_nxt = PH_START2;
        end
        PH_START2: begin
          if (in_rx_byte != start_byte_r) begin
            emit      = 1'b1;
            is_stat   = 1'b1;
            code      = ST_NO_START2;
            phase_nxt = PH_DONE;
          end else begin
            sum_nxt   = sum_r + in_rx_byte;
            phase_nxt = PH_CTRL;
          end
        end
        PH_CTRL: begin
          ctrl_nxt  = in_rx_byte;
          sum_nxt   = sum_r + in_rx_byte;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          len_nxt   = in_rx_byte;
          sum_nxt   = sum_r + in_rx_byte;
          idx_nxt   = 8'd0;
          phase_nxt = (in_rx_byte == 8'd0) ? PH_CS : PH_DATA;
        end
        PH_DATA: begin
          sum_nxt = sum_r + in_rx_byte;
          idx_nxt = idx_r + 8'd1;
          if (idx_nxt >= len_r) phase_nxt = PH_CS;
          if (!in_buffer_last) emit = 1'b1;
        end
        PH_CS: begin
          good_nxt  = (in_rx_byte == sum_r);
          phase_nxt = PH_END;
        end
        PH_END: begin
          emit      = 1'b1;
          is_stat   = 1'b1;
          phase_nxt = PH_DONE;
          if (in_rx_byte != end_byte_r) begin
            code = ST_NO_END;
          end else if (!good_r) begin
            code = ST_BAD_SUM;
          end else begin
            code = ST_OK;
            cons = pos_inc;
          end
        end
        PH_DONE: ;
        default: phase_nxt = PH_DONE;
      endcase

      if (in_buffer_last && !emit && phase_nxt != PH_DONE) begin
        emit    = 1'b1;
        is_stat = 1'b1;
        code    = (phase_nxt == PH_HUNT) ? ST_NO_START : ST_TRUNCATED;
      end

      addr_ext = 64'(addr_nxt);
      if (is_stat) begin
        res.kind          = KIND_STATUS;
        res.meter_address = addr_ext[47:0];
        res.control_code  = ctrl_nxt;
        res.data_length   = len_nxt;
        res.status        = code;
        res.consumed      = cons;
      end else begin
        res.kind    = KIND_PAYLOAD;
        res.payload = in_rx_byte;
      end

      if (in_buffer_last) begin
        phase_nxt = PH_HUNT;
        pos_nxt   = 8'd0;
        idx_nxt   = 8'd0;
        addr_nxt  = '0;
        ctrl_nxt  = 8'd0;
        len_nxt   = 8'd0;
        sum_nxt   = 8'd0;
        good_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= START_BYTE_RST;
      end_byte_r   <= END_BYTE_RST;
      phase_r      <= PH_HUNT;
      idx_r        <= 8'd0;
      addr_r       <= '0;
      ctrl_r       <= 8'd0;
      len_r        <= 8'd0;
      sum_r        <= 8'd0;
      pos_r        <= 8'd0;
      good_r       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_START_BYTE) start_byte_r <= cfg_data;
        if (cfg_index == CFG_END_BYTE)   end_byte_r   <= cfg_data;
      end
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      addr_r  <= addr_nxt;
      ctrl_r  <= ctrl_nxt;
      len_r   <= len_nxt;
      sum_r   <= sum_nxt;
      pos_r   <= pos_nxt;
      good_r  <= good_nxt;
    end
  end

  // result register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_stall) begin
        if (emit) skid_valid_r <= 1'b1;
      end else if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && out_stall) begin
      if (emit) skid_r <= res;
    end else if (skid_valid_r) begin
      out_r <= skid_r;
    end else if (emit) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_r.kind;
  assign out_payload       = out_r.payload;
  assign out_meter_address = out_r.meter_address;
  assign out_control_code  = out_r.control_code;
  assign out_data_length   = out_r.data_length;
  assign out_status        = out_r.status;
  assign out_consumed      = out_r.consumed;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without a result in the output register");

  a_last_rehunts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_buffer_last) |=> (phase_r == PH_HUNT && pos_r == 8'd0))
    else $error("buffer end did not return the parser to hunting");

  a_addr_index: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ADDR) |-> (idx_r < 8'(ADDRESS_BYTES)))
    else $error("address byte index out of range");

  a_data_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (len_r != 8'd0))
    else $error("data phase entered with zero length");
`endif

endmodule
